FILE: rtl/fjpt_pkg.sv
package fjpt_pkg;

  localparam int unsigned MAX_DOC_BYTES = 65536;
  // byte counter has to be able to hold MAX_DOC_BYTES itself
  localparam int POS_W = $clog2(MAX_DOC_BYTES + 1);
  localparam int OFS_W = 16;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [OFS_W-1:0] ofs_t;

  typedef enum logic [1:0] {
    KIND_KEY   = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_BRACE  = 3'd1,
    ERR_EMPTY  = 3'd2,
    ERR_CLOSE  = 3'd3,
    ERR_UNTERM = 3'd4,
    ERR_LONG   = 3'd5
  } err_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       begin_req;
  } in_t;

  typedef struct packed {
    kind_t      kind;
    ofs_t       pair_index;
    ofs_t       span_start;
    ofs_t       span_end;
    logic       is_text;
    err_t       error_code;
    logic       done_res;
  } out_t;

  typedef struct packed {
    logic in_key;
    logic atom_open;
    logic string_open;
    logic finished;
    pos_t byte_pos;
    ofs_t key_begin;
    ofs_t value_begin;
    ofs_t last_nonspace;
    logic last_was_quote;
    ofs_t pair_count;
  } state_t;

  localparam state_t STATE_RESET = '{
    in_key:         1'b1,
    atom_open:      1'b0,
    string_open:    1'b0,
    finished:       1'b1,
    byte_pos:       '0,
    key_begin:      '0,
    value_begin:    '0,
    last_nonspace:  '0,
    last_was_quote: 1'b0,
    pair_count:     '0
  };

endpackage

FILE: rtl/fjpt_step.sv
module fjpt_step
  import fjpt_pkg::*;
(
  input  in_t    beat,
  input  state_t st,
  output state_t st_nxt,
  output logic   has_res,
  output out_t   res
);

  always_comb begin
    state_t s;
    err_t   err;
    logic   span_hit;
    logic   advance;
    kind_t  span_kind;
    ofs_t   span_begin;
    logic   span_done;

    s = st;
    if (beat.begin_req) begin
      s = STATE_RESET;
      s.finished = 1'b0;
    end
    st_nxt     = s;
    err        = ERR_NONE;
    span_hit   = 1'b0;
    advance    = 1'b0;
    span_kind  = KIND_KEY;
    span_begin = s.key_begin;
    span_done  = 1'b0;

    if (!s.finished) begin
      if (s.byte_pos >= pos_t'(MAX_DOC_BYTES)) begin
        err = ERR_LONG;
      end else if (beat.ch == CH_NUL) begin
        err = ERR_UNTERM;
      end else if (beat.ch == CH_RBRACE) begin
        if (s.string_open || s.in_key) begin
          err = ERR_BRACE;
        end else if (!s.atom_open) begin
          err = ERR_EMPTY;
        end else begin
          span_hit        = 1'b1;
          span_kind       = KIND_VALUE;
          span_begin      = s.value_begin;
          span_done       = 1'b1;
          st_nxt.finished = 1'b1;
        end
      end else if (beat.ch == CH_COLON && !s.string_open) begin
        if (!s.atom_open || !s.in_key) begin
          err = ERR_CLOSE;
        end else begin
          span_hit         = 1'b1;
          advance          = 1'b1;
          st_nxt.in_key    = 1'b0;
          st_nxt.atom_open = 1'b0;
        end
      end else if (beat.ch == CH_COMMA && !s.string_open) begin
        if (!s.atom_open || s.in_key) begin
          err = ERR_CLOSE;
        end else begin
          span_hit          = 1'b1;
          span_kind         = KIND_VALUE;
          span_begin        = s.value_begin;
          advance           = 1'b1;
          st_nxt.pair_count = s.pair_count + ofs_t'(1);
          st_nxt.atom_open  = 1'b0;
          st_nxt.in_key     = 1'b1;
        end
      end else begin
        advance = 1'b1;
        if (beat.ch == CH_QUOTE) begin
          st_nxt.string_open = !s.string_open;
        end else if ((beat.ch == CH_SPACE || beat.ch == CH_LBRACE) && !s.string_open) begin
          // skipped
        end else if (!s.atom_open) begin
          if (s.in_key) begin
            st_nxt.key_begin = ofs_t'(s.byte_pos);
          end else begin
            st_nxt.value_begin = ofs_t'(s.byte_pos);
          end
          st_nxt.atom_open = 1'b1;
        end
      end
    end

    if (advance) begin
      if (beat.ch != CH_SPACE) begin
        st_nxt.last_nonspace  = ofs_t'(s.byte_pos);
        st_nxt.last_was_quote = (beat.ch == CH_QUOTE);
      end
      st_nxt.byte_pos = s.byte_pos + pos_t'(1);
    end

    res.pair_index = s.pair_count;
    if (err != ERR_NONE) begin
      st_nxt.finished = 1'b1;
      has_res         = 1'b1;
      res.kind        = KIND_ERROR;
      res.span_start  = ofs_t'(s.byte_pos);
      res.span_end    = ofs_t'(s.byte_pos);
      res.is_text     = 1'b0;
      res.error_code  = err;
      res.done_res    = 1'b1;
    end else begin
      has_res        = span_hit;
      res.kind       = span_kind;
      res.span_start = span_begin;
      // a quoted span ends at its closing quote, a bare one just past its last byte
      res.span_end   = s.last_was_quote ? s.last_nonspace : s.last_nonspace + ofs_t'(1);
      res.is_text    = s.last_was_quote;
      res.error_code = ERR_NONE;
      res.done_res   = span_done;
    end
  end

endmodule

FILE: rtl/flat_json_pair_tokenizer_core.sv
// An accepted input beat passes the input register, then the output register, to reach out_valid/out_data.
// Throughput: one byte per cycle unless out_ready stalls the output; an input register feeds
// one pass of step logic that updates the parser state and loads the output register in the same cycle.
// Bytes that produce no result still pass through the step stage.
// Reset (rst_n low, synchronous) empties both registers and leaves the parser
// waiting for a beat with begin_req set.
module flat_json_pair_tokenizer_core
  import fjpt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic   in_valid_r;
  in_t    in_data_r;
  state_t st_r;
  state_t st_nxt;
  logic   out_valid_r;
  out_t   out_data_r;
  logic   step_has_res;
  out_t   step_res;
  logic   step_fire;

  assign step_fire = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || step_fire;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  fjpt_step u_step (
    .beat    (in_data_r),
    .st      (st_r),
    .st_nxt  (st_nxt),
    .has_res (step_has_res),
    .res     (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= STATE_RESET;
    end else if (step_fire) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_fire) begin
      out_valid_r <= step_has_res;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire && step_has_res) begin
      out_data_r <= step_res;
    end
  end

`ifndef SYNTH
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.byte_pos <= pos_t'(MAX_DOC_BYTES))
    else $error("byte counter past document limit");

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.kind == KIND_ERROR) |->
      (out_data_r.done_res && !out_data_r.is_text &&
       out_data_r.span_start == out_data_r.span_end &&
       out_data_r.error_code != ERR_NONE))
    else $error("malformed error beat");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (step_fire && st_r.finished && !in_data_r.begin_req) |=> $stable(st_r))
    else $error("parser state moved while waiting for begin");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (step_fire && st_r.finished && !in_data_r.begin_req) |-> !step_has_res)
    else $error("result produced while waiting for begin");

  a_done_finished: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.done_res) |-> st_r.finished)
    else $error("document end reported but parser still open");
`endif

endmodule
